// ----- rtl/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and crc helpers for the command frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

   localparam logic [7:0]  SYNC_BYTE      = 8'h55;
   localparam logic [7:0]  VERSION_BITS   = 8'h04;
   localparam logic [7:0]  LEN_HIGH_MASK  = 8'h03;
   localparam logic [9:0]  FRAME_OVERHEAD = 10'd13;
   localparam logic [7:0]  CRC8_SEED      = 8'h77;
   localparam logic [7:0]  CRC8_POLY      = 8'h8C;
   localparam logic [15:0] CRC16_SEED     = 16'h3692;
   localparam logic [15:0] CRC16_POLY     = 16'h8408;

   // byte positions inside one queue entry
   localparam logic [3:0] IDX_LEN_LO   = 4'd1;
   localparam logic [3:0] IDX_LEN_HI   = 4'd2;
   localparam logic [3:0] IDX_HDR_CRC  = 4'd3;
   localparam logic [3:0] IDX_SENDER   = 4'd4;
   localparam logic [3:0] IDX_RECEIVER = 4'd5;
   localparam logic [3:0] IDX_ID_HI    = 4'd6;
   localparam logic [3:0] IDX_ID_LO    = 4'd7;
   localparam logic [3:0] IDX_FLAGS    = 4'd8;
   localparam logic [3:0] IDX_CMD_SET  = 4'd9;
   localparam logic [3:0] IDX_CMD_ID   = 4'd10;
   localparam logic [3:0] HDR_LAST_IDX = 4'd10;

   typedef enum logic {
      KIND_HEADER  = 1'b0,
      KIND_PAYLOAD = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  sender;
      logic [7:0]  receiver;
      logic [15:0] msg_id;
      logic [7:0]  msg_flags;
      logic [7:0]  cmd_set;
      logic [7:0]  cmd_id;
      logic [9:0]  payload_length;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      kind_type    op;
      logic        close;      // trailer follows this entry
      logic [7:0]  sender;
      logic [7:0]  receiver;
      logic [15:0] msg_id;
      logic [7:0]  msg_flags;
      logic [7:0]  cmd_set;
      logic [7:0]  cmd_id;
      logic [9:0]  total_len;
      logic [7:0]  data;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/cfb_front.sv -----
// ----------------------------------------------------------------------------
// cfb_front
// Accepts request items, tracks the open frame and queues work for the back.
// ----------------------------------------------------------------------------
module cfb_front
   import cfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_entry
);

   logic [9:0] remaining_ff, remaining_in;
   logic       accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      remaining_in          = remaining_ff;
      push                  = 1'b0;
      push_entry.op         = kind_type'(req_data.kind);
      push_entry.close      = 1'b0;
      push_entry.sender     = req_data.sender;
      push_entry.receiver   = req_data.receiver;
      push_entry.msg_id     = req_data.msg_id;
      push_entry.msg_flags  = req_data.msg_flags;
      push_entry.cmd_set    = req_data.cmd_set;
      push_entry.cmd_id     = req_data.cmd_id;
      push_entry.total_len  = req_data.payload_length + FRAME_OVERHEAD;
      push_entry.data       = req_data.payload_byte;
      if (accept) begin
         if (req_data.kind == KIND_HEADER) begin
            // a new header drops any frame still open
            push             = 1'b1;
            push_entry.close = (req_data.payload_length == 10'd0);
            remaining_in     = req_data.payload_length;
         end else if (remaining_ff != 10'd0) begin
            push             = 1'b1;
            push_entry.close = (remaining_ff == 10'd1);
            remaining_in     = remaining_ff - 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 10'd0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ----- rtl/cfb_queue.sv -----
// ----------------------------------------------------------------------------
// cfb_queue
// Two-entry queue that decouples the front from the byte serializer.
// ----------------------------------------------------------------------------
module cfb_queue
   import cfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head,
   output q_status_type q_status
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.valid = (count_ff != 2'd0);
   assign q_status.full  = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/cfb_back.sv -----
// ----------------------------------------------------------------------------
// cfb_back
// Serializes queue entries into frame bytes, runs both crcs, drives the
// response register.
// ----------------------------------------------------------------------------
module cfb_back
   import cfb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  crc8_ff, crc8_in;
   logic [15:0] crc16_ff, crc16_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        fire;
   logic [3:0]  data_last;
   logic [3:0]  entry_last;
   logic        is_trailer_lo, is_trailer_hi;
   logic [7:0]  byte_sel;
   logic [7:0]  crc8_base;
   logic [15:0] crc16_base;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign fire          = q_status.valid && (!rsp_valid_ff || rsp_ready);
   assign data_last     = (head.op == KIND_HEADER) ? HDR_LAST_IDX : 4'd0;
   assign is_trailer_lo = head.close && (idx_ff == data_last + 4'd1);
   assign is_trailer_hi = head.close && (idx_ff == data_last + 4'd2);
   assign entry_last    = head.close ? data_last + 4'd2 : data_last;
   assign pop           = fire && (idx_ff == entry_last);

   always_comb begin
      if (head.op == KIND_HEADER) begin
         case (idx_ff)
            4'd0:         byte_sel = SYNC_BYTE;
            IDX_LEN_LO:   byte_sel = head.total_len[7:0];
            IDX_LEN_HI:   byte_sel = VERSION_BITS |
                                     ({6'd0, head.total_len[9:8]} & LEN_HIGH_MASK);
            IDX_HDR_CRC:  byte_sel = crc8_ff;
            IDX_SENDER:   byte_sel = head.sender;
            IDX_RECEIVER: byte_sel = head.receiver;
            IDX_ID_HI:    byte_sel = head.msg_id[15:8];
            IDX_ID_LO:    byte_sel = head.msg_id[7:0];
            IDX_FLAGS:    byte_sel = head.msg_flags;
            IDX_CMD_SET:  byte_sel = head.cmd_set;
            IDX_CMD_ID:   byte_sel = head.cmd_id;
            default:      byte_sel = 8'h00;
         endcase
      end else begin
         byte_sel = head.data;
      end
      if (is_trailer_lo) begin
         byte_sel = crc16_ff[7:0];
      end else if (is_trailer_hi) begin
         byte_sel = crc16_ff[15:8];
      end
   end

   always_comb begin
      // the header restarts both crcs on its sync byte
      crc8_base  = (idx_ff == 4'd0) ? CRC8_SEED : crc8_ff;
      crc16_base = (head.op == KIND_HEADER && idx_ff == 4'd0) ? CRC16_SEED : crc16_ff;

      idx_in       = idx_ff;
      crc8_in      = crc8_ff;
      crc16_in     = crc16_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = byte_sel;
         rsp_data_in.frame_end = is_trailer_hi;
         rsp_data_in.run_last  = (idx_ff == entry_last);
         idx_in                = pop ? 4'd0 : idx_ff + 4'd1;
         if (head.op == KIND_HEADER && idx_ff < IDX_HDR_CRC) begin
            crc8_in = crc8_update(crc8_base, byte_sel);
         end
         if (is_trailer_hi) begin
            crc16_in = CRC16_SEED;
         end else if (!is_trailer_lo) begin
            crc16_in = crc16_update(crc16_base, byte_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      crc8_ff     <= crc8_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         crc16_ff     <= CRC16_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc16_ff     <= crc16_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/command_frame_builder_crc8_crc16_core.sv -----
// ----------------------------------------------------------------------------
// command_frame_builder_crc8_crc16_core
// Command frame builder: header and payload items in, framed bytes out with
// a crc-8 header check and a crc-16 frame check.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data (req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data (rsp_type)
//
// a payload item yields one byte, its last one also the crc-16 pair
// a header yields eleven bytes, thirteen with an empty payload; when not
// stalled, the serializer emits one byte per cycle through the rsp register
// a two-entry queue lets the front take items while the serializer works
// synchronous active-high reset empties the queue and the response register
// an rsp stall holds the serializer; req stalls only when the queue is full
// ----------------------------------------------------------------------------
module command_frame_builder_crc8_crc16_core
   import cfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   entry_type    push_entry;
   entry_type    head;

   cfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   cfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   cfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // the closing crc byte always ends the run of its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.run_last)
      else $error("frame_end without run_last");

   // an accepted header is queued and cannot be drained in the same cycle
   a_header_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_HEADER |=> q_status.valid)
      else $error("accepted header not queued");

   // nothing is presented in the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the serializer never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("pop from empty queue");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the command frame builder. Header and payload items go in
// through a random-gap sender. The bytes that come out are checked in order
// against a predictor that rebuilds every frame byte, the header crc-8 and the
// trailing crc-16. The receiver stalls at random, and once it holds off for
// a long stretch.
// ----------------------------------------------------------------------------
module tb;
   import cfb_pkg::*;

   class frame_scoreboard;
      rsp_type     expected_bytes[$];
      logic [15:0] frame_crc;
      logic [9:0]  bytes_left;
      bit          in_frame;
      int unsigned errors;
      int unsigned bytes_checked;
      int unsigned frames_closed;
      int unsigned frames_dropped;
      int unsigned strays;
      int unsigned productive;

      function new();
         frame_crc      = CRC16_SEED;
         bytes_left     = '0;
         in_frame       = 1'b0;
         errors         = 0;
         bytes_checked  = 0;
         frames_closed  = 0;
         frames_dropped = 0;
         strays         = 0;
         productive     = 0;
      endfunction

      // reflected crc, one data bit per step
      function logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] b);
         logic [7:0] c;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) c = (c >> 1) ^ CRC8_POLY;
            else c = c >> 1;
         end
         return c;
      endfunction

      function logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) c = (c >> 1) ^ CRC16_POLY;
            else c = c >> 1;
         end
         return c;
      endfunction

      function void emit_byte(logic [7:0] b);
         rsp_type r;
         r.out_byte  = b;
         r.frame_end = 1'b0;
         r.run_last  = 1'b0;
         expected_bytes.push_back(r);
         frame_crc = crc16_fold(frame_crc, b);
      endfunction

      function void emit_trailer();
         rsp_type r;
         r.out_byte  = frame_crc[7:0];
         r.frame_end = 1'b0;
         r.run_last  = 1'b0;
         expected_bytes.push_back(r);
         r.out_byte  = frame_crc[15:8];
         r.frame_end = 1'b1;
         expected_bytes.push_back(r);
         frame_crc  = CRC16_SEED;
         bytes_left = '0;
         in_frame   = 1'b0;
         frames_closed++;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 40) $display("mismatch: %s", msg);
      endtask

      task note_request(input req_type item);
         logic [9:0]  total;
         logic [7:0]  len_hi;
         logic [7:0]  hdr_crc;
         int unsigned queued;
         queued = expected_bytes.size();
         if (item.kind == KIND_HEADER) begin
            if (in_frame) frames_dropped++;
            total   = item.payload_length + FRAME_OVERHEAD;
            len_hi  = VERSION_BITS | ({6'b0, total[9:8]} & LEN_HIGH_MASK);
            hdr_crc = crc8_fold(crc8_fold(crc8_fold(CRC8_SEED, SYNC_BYTE), total[7:0]),
                                len_hi);
            frame_crc  = CRC16_SEED;
            in_frame   = 1'b1;
            bytes_left = item.payload_length;
            emit_byte(SYNC_BYTE);
            emit_byte(total[7:0]);
            emit_byte(len_hi);
            emit_byte(hdr_crc);
            emit_byte(item.sender);
            emit_byte(item.receiver);
            emit_byte(item.msg_id[15:8]);
            emit_byte(item.msg_id[7:0]);
            emit_byte(item.msg_flags);
            emit_byte(item.cmd_set);
            emit_byte(item.cmd_id);
            if (bytes_left == 0) emit_trailer();
         end else if (in_frame && bytes_left != 0) begin
            emit_byte(item.payload_byte);
            bytes_left--;
            if (bytes_left == 0) emit_trailer();
         end else begin
            strays++;
         end
         if (expected_bytes.size() > queued) begin
            productive++;
            expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
         end
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %02h arrived with nothing expected", got.out_byte));
            return;
         end
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (got.out_byte !== want.out_byte)
            report($sformatf("byte %0d: out_byte %02h, expected %02h",
                             bytes_checked, got.out_byte, want.out_byte));
         if (got.frame_end !== want.frame_end)
            report($sformatf("byte %0d: frame_end %b, expected %b",
                             bytes_checked, got.frame_end, want.frame_end));
         if (got.run_last !== want.run_last)
            report($sformatf("byte %0d: run_last %b, expected %b",
                             bytes_checked, got.run_last, want.run_last));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit calm         = 1'b0;
   bit hold_trigger = 1'b0;

   frame_scoreboard sb = new();

   command_frame_builder_crc8_crc16_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic req_type make_header(logic [7:0] snd, logic [7:0] rcv, logic [15:0] id,
                                           logic [7:0] flg, logic [7:0] cset, logic [7:0] cid,
                                           logic [9:0] plen, logic [7:0] pbyte);
      req_type r;
      r.kind           = KIND_HEADER;
      r.sender         = snd;
      r.receiver       = rcv;
      r.msg_id         = id;
      r.msg_flags      = flg;
      r.cmd_set        = cset;
      r.cmd_id         = cid;
      r.payload_length = plen;
      r.payload_byte   = pbyte;
      return r;
   endfunction

   function automatic req_type random_header(logic [9:0] plen);
      return make_header(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), plen, 8'($urandom));
   endfunction

   // header fields on a payload item are don't-care, so fill them with noise
   function automatic req_type payload_item(logic [7:0] b);
      req_type r;
      r              = random_header(10'($urandom));
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      return r;
   endfunction

   task automatic send_item(input req_type item);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // receiver: checks each transfer, stalls at random, honors one long hold-off
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_left    = 300;
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 11);
         end
         @(posedge clock);
      end
   end

   initial begin
      int unsigned plen;
      int unsigned sent;
      int unsigned frame_no;
      int unsigned start_count;
      bit          cut;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray byte, extremes, oversized and wrapped lengths, abandoned frames
      send_item(payload_item(8'($urandom)));
      send_item(make_header(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd0, 8'h00));
      send_item(make_header(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd1023, 8'hFF));
      send_item(payload_item(8'h00));
      send_item(payload_item(8'hFF));
      send_item(random_header(10'd1010));
      send_item(payload_item(8'h5A));
      send_item(random_header(10'd1011));
      send_item(random_header(10'd1));
      send_item('1);
      send_item(payload_item(8'hA5));
      send_item(make_header(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd2, 8'hFF));
      send_item(payload_item(8'h80));
      send_item(payload_item(8'h01));
      send_item(payload_item(8'h7E));
      send_item(make_header(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd0, 8'hFF));

      // random frames, now and then cut short or followed by stray bytes
      start_count = sb.productive;
      frame_no = 0;
      while (sb.productive - start_count < 140) begin
         frame_no++;
         calm = (frame_no >= 14 && frame_no <= 20);
         if (frame_no == 10) wait_drained();
         if (frame_no == 5) begin
            hold_trigger = 1'b1;
            plen = 24;
            cut  = 1'b0;
         end else begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            cut  = (plen != 0) && ($urandom_range(0, 9) == 0);
         end
         send_item(random_header(10'(plen)));
         sent = cut ? $urandom_range(0, plen - 1) : plen;
         for (int i = 0; i < sent; i++) send_item(payload_item(8'($urandom)));
         if (!cut && $urandom_range(0, 5) == 0) send_item(payload_item(8'($urandom)));
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) sb.report("expected bytes never arrived");

      $display("covered %0d frames closed, %0d abandoned by a new header, %0d stray bytes",
               sb.frames_closed, sb.frames_dropped, sb.strays);
      $display("%0d output bytes compared, %0d mismatches", sb.bytes_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
